// File: design/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// No dependencies; every other file of the block but lir_ram imports this package.
`timescale 1ns / 1ps

package lir_pkg;

  // Field widths
  localparam int IDX_W   = 12;
  localparam int SMP_W   = 16;
  localparam int LEN_W   = 13;
  localparam int STEP_W  = 24;
  localparam int FRAC_W  = 16;

  // Read position = index * step, Q(n).16
  localparam int POS_W   = IDX_W + STEP_W;
  localparam int N_W     = POS_W - FRAC_W;
  localparam int CMP_W   = N_W + 1;

  // Blend datapath
  localparam int DIFF_W  = SMP_W + 1;
  localparam int PROD_W  = DIFF_W + FRAC_W + 1;
  localparam int SH_W    = PROD_W - FRAC_W;

  // Register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [LEN_W-1:0]  LEN_RESET  = '0;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'h01_0000;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    REG_BLOCK_LENGTH = 1'b0,
    REG_READ_STEP    = 1'b1
  } reg_e;

  // What the back end has to do with one word
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_BLEND  = 2'd1,
    CMD_SINGLE = 2'd2,
    CMD_ZERO   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                     kind;
    logic [IDX_W-1:0]         idx;
    logic [N_W-1:0]           n;       // store address (write index or integer position)
    logic [FRAC_W-1:0]        frac;
    logic signed [SMP_W-1:0]  sample;
  } cmd_t;

endpackage

// File: design/lir_if.sv
// Valid/ready channel interfaces for the resampler input and result words.
// Depends on lir_pkg.
`timescale 1ns / 1ps

interface lir_in_if;
  import lir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [IDX_W-1:0]        index;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, opcode, index, sample, input ready);
  modport sink   (input valid, opcode, index, sample, output ready);
endinterface

interface lir_out_if;
  import lir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] out_sample;
  logic [IDX_W-1:0]        out_index;

  modport source (output valid, out_sample, out_index, input ready);
  modport sink   (input valid, out_sample, out_index, output ready);
endinterface

// File: design/linear_interp_resampler.sv
// Top level of the linear interpolation resampler: register port, front end,
// command queue and back end. Depends on lir_pkg, lir_if and all lir_ modules.
`timescale 1ns / 1ps

// Usage
//   in_i  : input words. opcode 0 writes sample into the store at index,
//           opcode 1 queries output position index. Writes give no result.
//   out_o : one result word per query: out_sample and the echoed out_index.
//   APB   : block_length at 0x0, read_step (Q8.16) at 0x4. Write only while idle.
// Timing
//   The front end registers each word with its read position (index * step)
//   and takes a new word every cycle while the two-entry command queue has room.
//   The back end owns the single-port sample store and sets the rate: a write or
//   an out-of-range query uses state S_IDLE only, a single-neighbor query S_IDLE
//   and S_RDA, a blended query S_IDLE, S_RDA, S_RDB and S_MUL (two store
//   reads, one multiply, one round-and-add). Each query passes the front
//   stage register, the command queue and those states into the result register.
// Stall: a held result blocks the next query in the back end and everything
//   queued behind it; the front end keeps taking words until the queue
//   fills, then in_i.ready drops.
// Reset: block_length 0, read_step 1.0, queue empty, no result pending.
//   The sample store is not cleared; read only entries that were written.

module linear_interp_resampler #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lir_in_if.sink                      in_i,
  lir_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lir_pkg::PADDR_W-1:0] paddr,
  input  logic [lir_pkg::PDATA_W-1:0] pwdata,
  output logic [lir_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import lir_pkg::*;

  logic [LEN_W-1:0]  blen_q;
  logic [STEP_W-1:0] step_q;
  logic              reg_wr;
  reg_e              reg_sel;

  cmd_t front_cmd;
  cmd_t fifo_cmd;
  logic push;
  logic full;
  logic pop;
  logic fifo_valid;

  // Register port
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= LEN_RESET;
      step_q <= STEP_RESET;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_BLOCK_LENGTH: blen_q <= pwdata[LEN_W-1:0];
        REG_READ_STEP:    step_q <= pwdata[STEP_W-1:0];
        default:          blen_q <= blen_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_LENGTH: prdata = PDATA_W'(blen_q);
      REG_READ_STEP:    prdata = PDATA_W'(step_q);
      default:          prdata = '0;
    endcase
  end

  lir_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .blen_i (blen_q),
    .step_i (step_q),
    .cmd_o  (front_cmd),
    .push_o (push),
    .full_i (full)
  );

  lir_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .cmd_o   (fifo_cmd)
  );

  lir_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (fifo_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// File: design/lir_ram.sv
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lir_front.sv
// Front end: accepts words, computes the read position, classifies each word
// into a back-end command. Depends on lir_pkg and lir_if.
`timescale 1ns / 1ps

module lir_front #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lir_in_if.sink                     in_i,
  input  logic [lir_pkg::LEN_W-1:0]  blen_i,
  input  logic [lir_pkg::STEP_W-1:0] step_i,
  output lir_pkg::cmd_t              cmd_o,
  output logic                       push_o,
  input  logic                       full_i
);
  import lir_pkg::*;

  localparam logic [CMP_W-1:0] MaxExt = CMP_W'(MAX_SAMPLES);

  logic                    vld_q;
  logic                    op_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [SMP_W-1:0] smp_q;
  logic [POS_W-1:0]        pos_q;
  logic [POS_W-1:0]        pos_d;

  logic [N_W-1:0]    n;
  logic [FRAC_W-1:0] frac;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  len_sat;
  logic [CMP_W-1:0]  n_ext;
  logic [CMP_W-1:0]  n1_ext;
  logic              wr_ok;
  logic              drop;
  logic              done;
  logic              take;

  // Position multiply on the way in
  assign pos_d = POS_W'(in_i.index) * POS_W'(step_i);

  assign in_i.ready = !vld_q || done;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (done) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= in_i.opcode;
      idx_q <= in_i.index;
      smp_q <= in_i.sample;
      pos_q <= pos_d;
    end
  end

  // Classify against the saturated block length
  assign n       = pos_q[POS_W-1:FRAC_W];
  assign frac    = pos_q[FRAC_W-1:0];
  assign len_ext = CMP_W'(blen_i);
  assign len_sat = (len_ext > MaxExt) ? MaxExt : len_ext;
  assign n_ext   = CMP_W'(n);
  assign n1_ext  = n_ext + CMP_W'(1);
  assign wr_ok   = CMP_W'(idx_q) < MaxExt;

  always_comb begin
    cmd_o.idx    = idx_q;
    cmd_o.frac   = frac;
    cmd_o.sample = smp_q;
    cmd_o.n      = n;
    if (op_q == OP_WRITE) begin
      cmd_o.kind = CMD_WRITE;
      cmd_o.n    = N_W'(idx_q);
    end else if (n1_ext < len_sat) begin
      cmd_o.kind = CMD_BLEND;
    end else if (n_ext < len_sat) begin
      cmd_o.kind = CMD_SINGLE;
    end else begin
      cmd_o.kind = CMD_ZERO;
    end
  end

  // Out-of-range writes are dropped here
  assign drop   = vld_q && (op_q == OP_WRITE) && !wr_ok;
  assign push_o = vld_q && !drop && !full_i;
  assign done   = drop || push_o;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !done |=> vld_q && $stable(pos_q) && $stable(idx_q))
    else $error("front stage lost a word while the queue was full");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o)
    else $error("push into full queue");

  a_drop_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |-> !push_o && (op_q == OP_WRITE))
    else $error("dropped word was also pushed");

endmodule

// File: design/lir_cmd_fifo.sv
// Two-entry command queue between front and back end.
// Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lir_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lir_pkg::cmd_t cmd_o
);
  import lir_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      priority if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end else begin
        cnt_q <= cnt_q;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue underflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

endmodule

// File: design/lir_back.sv
// Back end: runs commands against the sample store, blends two neighbors and
// drives the result register. Depends on lir_pkg, lir_if and lir_ram.
`timescale 1ns / 1ps

module lir_back #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  lir_pkg::cmd_t cmd_i,
  output logic          pop_o,
  lir_out_if.source     out_o
);
  import lir_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RDA  = 4'b0010,
    S_RDB  = 4'b0100,
    S_MUL  = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  cmd_e                     kind_q;
  logic [IDX_W-1:0]         idx_q;
  logic [FRAC_W-1:0]        frac_q;
  logic [AW-1:0]            addr_q;
  logic signed [SMP_W-1:0]  a_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;

  logic                    out_vld_q;
  logic signed [SMP_W-1:0] out_smp_q;
  logic [IDX_W-1:0]        out_idx_q;

  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           ram_addr;
  logic [SMP_W-1:0]        ram_rdata;
  logic signed [SMP_W-1:0] rdata_s;

  logic                    out_free;
  logic                    ld_cmd;
  logic                    ld_a;
  logic                    ld_prod;
  logic                    ld_out;
  logic signed [SMP_W-1:0] res;
  logic [IDX_W-1:0]        res_idx;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] rsum;
  logic signed [SH_W-1:0]   rsh;
  logic signed [SH_W-1:0]   blended;

  lir_ram #(
    .WIDTH (SMP_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.sample),
    .rdata_o (ram_rdata)
  );

  assign rdata_s  = $signed(ram_rdata);
  assign out_free = !out_vld_q || out_o.ready;

  // Blend: a + round((b - a) * f / 2^16), exact match to the two-product form
  assign diff    = DIFF_W'(rdata_s) - DIFF_W'(a_q);
  assign prod_d  = diff * $signed({1'b0, frac_q});
  assign rsum    = prod_q + $signed(ROUND_HALF);
  assign rsh     = rsum[PROD_W-1:FRAC_W];
  assign blended = SH_W'(a_q) + rsh;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = AW'(cmd_i.n);
    ld_cmd   = 1'b0;
    ld_a     = 1'b0;
    ld_prod  = 1'b0;
    ld_out   = 1'b0;
    res      = a_q;
    res_idx  = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_WRITE: begin
              ram_we = 1'b1;
              pop_o  = 1'b1;
            end
            CMD_ZERO: begin
              if (out_free) begin
                pop_o   = 1'b1;
                ld_out  = 1'b1;
                res     = '0;
                res_idx = cmd_i.idx;
              end
            end
            CMD_BLEND, CMD_SINGLE: begin
              pop_o   = 1'b1;
              ram_re  = 1'b1;
              ld_cmd  = 1'b1;
              state_d = S_RDA;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RDA: begin
        if (kind_q == CMD_BLEND) begin
          ld_a     = 1'b1;
          ram_re   = 1'b1;
          ram_addr = addr_q + AW'(1);
          state_d  = S_RDB;
        end else if (out_free) begin
          ld_out  = 1'b1;
          res     = rdata_s;
          state_d = S_IDLE;
        end
      end
      S_RDB: begin
        ld_prod = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (out_free) begin
          ld_out  = 1'b1;
          res     = SMP_W'(blended);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ld_cmd) begin
      kind_q <= cmd_i.kind;
      idx_q  <= cmd_i.idx;
      frac_q <= cmd_i.frac;
      addr_q <= AW'(cmd_i.n);
    end
    if (ld_a) begin
      a_q <= rdata_s;
    end
    if (ld_prod) begin
      prod_q <= prod_d;
    end
    if (ld_out) begin
      out_smp_q <= res;
      out_idx_q <= res_idx;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_sample = out_smp_q;
  assign out_o.out_index  = out_idx_q;

  a_rdb_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RDB |-> kind_q == CMD_BLEND)
    else $error("second read for a non-blend query");

  a_rdb_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RDB |=> state_q == S_MUL)
    else $error("blend did not proceed to multiply");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_out |-> !out_vld_q || out_o.ready)
    else $error("result register overwritten while held");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> cmd_valid_i && state_q == S_IDLE)
    else $error("pop without a pending command");

endmodule
